/* src/pnns_pkg.sv */
// Shared types, constants and the square-root step for the pose search block.
// Used by pnns_ctrl, pnns_dpath and the top level; depends on nothing.
package pnns_pkg;

   localparam int REF_DEPTH = 4096;
   localparam int IDX_W     = 12;
   localparam int CNT_W     = 13;
   localparam int POS_W     = 24;
   localparam int DIR_W     = 16;
   localparam int ENTRY_W   = 3 * POS_W + 3 * DIR_W;
   localparam int WGT_W     = 10;
   localparam int COST_W    = 25;
   localparam int RAD_W     = 50;
   localparam int ROOT_W    = 25;
   localparam int REM_W     = 28;
   localparam int SQRT_STEPS = RAD_W / 2;
   localparam int PIPE_LEN  = SQRT_STEPS + 5;

   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_QUERY  = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic append;
      logic load_query;
      logic issue;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic full;
      logic last_issue;
      logic pipe_busy;
      logic out_busy;
   } sts_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   function automatic sqrt_type sqrt_step(input sqrt_type s);
      sqrt_type          r;
      logic [REM_W-1:0]  cur;
      logic [REM_W-1:0]  trial;
      r     = s;
      cur   = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
      trial = {1'b0, s.root, 2'b01};
      r.rad = {s.rad[RAD_W-3:0], 2'b00};
      if (cur >= trial) begin
         r.rem  = cur - trial;
         r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = cur;
         r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

/* src/pnns_ram.sv */
// Generic single-port-write, registered-read RAM.
// Depends on nothing.
module pnns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/pnns_ctrl.sv */
// Sequencer for clear, append and query requests of the pose search block.
// Depends on pnns_pkg.
module pnns_ctrl import pnns_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_mode,
   input  sts_type    sts,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   mode_type  mode;

   assign mode = mode_type'(req_mode);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && mode == MODE_QUERY) begin
               state_in = sts.count_zero ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.last_issue) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!sts.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (mode)
                  MODE_CLEAR:  cmd.clear      = 1'b1;
                  MODE_APPEND: cmd.append     = !sts.full;
                  MODE_QUERY:  cmd.load_query = 1'b1;
                  default:     cmd            = '0;
               endcase
            end
         end
         ST_SCAN:   cmd.issue  = 1'b1;
         ST_FINISH: cmd.finish = !sts.out_busy;
         default:   cmd        = '0;
      endcase
   end

endmodule

/* src/pnns_dpath.sv */
// Reference store, pipelined cost unit, best-match tracking and result register.
// Depends on pnns_pkg and pnns_ram.
module pnns_dpath import pnns_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [ENTRY_W-1:0]  req_data,
   input  logic                csr_wen,
   input  logic [WGT_W-1:0]    csr_wdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [IDX_W-1:0]    rsp_index,
   output logic [COST_W-1:0]   rsp_cost,
   output logic                rsp_found
);

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   scan_addr_ff, scan_addr_in;
   logic [WGT_W-1:0]   weight_ff, weight_in;
   logic [ENTRY_W-1:0] query_ff;
   logic [ENTRY_W-1:0] rd_data;
   logic [CNT_W-1:0]   last_addr;

   logic               vld_ff [PIPE_LEN];
   logic [IDX_W-1:0]   idx_ff [PIPE_LEN];

   logic [POS_W-1:0]   pd_ff [3];
   logic [DIR_W-2:0]   od_ff [3];
   logic [2*POS_W-1:0] psq_ff [3];
   logic [2*DIR_W-3:0] osq_ff [3];
   sqrt_type           pin_ff, oin_ff;
   sqrt_type           pst_ff [SQRT_STEPS];
   sqrt_type           ost_ff [SQRT_STEPS];
   sqrt_type           pst_in [SQRT_STEPS];
   sqrt_type           ost_in [SQRT_STEPS];
   logic [ROOT_W-1:0]  proot_ff;
   logic [COST_W-1:0]  oterm_ff;
   logic [WGT_W+DIR_W-1:0] oprod;
   logic [COST_W:0]    cost;

   logic               best_valid_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [COST_W:0]    best_cost_ff;

   logic               out_valid_ff;
   logic [IDX_W-1:0]   out_index_ff;
   logic [COST_W-1:0]  out_cost_ff;
   logic               out_found_ff;
   logic               pipe_busy;

   pnns_ram #(.WIDTH(ENTRY_W), .DEPTH(REF_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_data),
      .rd_addr (scan_addr_ff),
      .rd_data (rd_data)
   );

   assign last_addr = count_ff - 1'b1;

   always_comb begin
      count_in     = count_ff;
      scan_addr_in = scan_addr_ff;
      weight_in    = csr_wen ? csr_wdata : weight_ff;
      if (cmd.clear) count_in = '0;
      if (cmd.append) count_in = count_ff + 1'b1;
      if (cmd.load_query) scan_addr_in = '0;
      if (cmd.issue) scan_addr_in = scan_addr_ff + 1'b1;
   end

   always_comb begin
      pipe_busy = 1'b0;
      for (int k = 0; k < PIPE_LEN; k++) pipe_busy = pipe_busy | vld_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         weight_ff    <= WGT_W'(100);
         out_valid_ff <= 1'b0;
         for (int k = 0; k < PIPE_LEN; k++) vld_ff[k] <= 1'b0;
      end else begin
         count_ff  <= count_in;
         weight_ff <= weight_in;
         vld_ff[0] <= cmd.issue;
         for (int k = 1; k < PIPE_LEN; k++) vld_ff[k] <= vld_ff[k-1];
         if (cmd.finish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      if (cmd.load_query) query_ff <= req_data;
      idx_ff[0] <= scan_addr_ff;
      for (int k = 1; k < PIPE_LEN; k++) idx_ff[k] <= idx_ff[k-1];
   end

   always_comb begin
      pst_in[0] = sqrt_step(pin_ff);
      ost_in[0] = sqrt_step(oin_ff);
      for (int k = 1; k < SQRT_STEPS; k++) begin
         pst_in[k] = sqrt_step(pst_ff[k-1]);
         ost_in[k] = sqrt_step(ost_ff[k-1]);
      end
   end

   assign oprod = (WGT_W+DIR_W)'(weight_ff)
                * (WGT_W+DIR_W)'(ost_ff[SQRT_STEPS-1].root[DIR_W-1:0]);

   always_ff @(posedge clock) begin
      logic signed [POS_W:0] pdiff;
      logic signed [DIR_W:0] odiff;
      logic        [POS_W:0] pmag;
      logic        [DIR_W:0] omag;
      for (int c = 0; c < 3; c++) begin
         pdiff = {rd_data[c*POS_W + POS_W-1], rd_data[c*POS_W +: POS_W]}
               - {query_ff[c*POS_W + POS_W-1], query_ff[c*POS_W +: POS_W]};
         pmag  = pdiff[POS_W] ? -pdiff : pdiff;
         pd_ff[c] <= pmag[POS_W-1:0];
         odiff = {rd_data[3*POS_W + c*DIR_W + DIR_W-1], rd_data[3*POS_W + c*DIR_W +: DIR_W]}
               - {query_ff[3*POS_W + c*DIR_W + DIR_W-1],
                  query_ff[3*POS_W + c*DIR_W +: DIR_W]};
         omag  = odiff[DIR_W] ? -odiff : odiff;
         od_ff[c] <= omag[DIR_W-2:0];
         psq_ff[c] <= pd_ff[c] * pd_ff[c];
         osq_ff[c] <= od_ff[c] * od_ff[c];
      end
      pin_ff.rad  <= RAD_W'(psq_ff[0]) + RAD_W'(psq_ff[1]) + RAD_W'(psq_ff[2]);
      pin_ff.rem  <= '0;
      pin_ff.root <= '0;
      oin_ff.rad  <= RAD_W'(osq_ff[0]) + RAD_W'(osq_ff[1]) + RAD_W'(osq_ff[2]);
      oin_ff.rem  <= '0;
      oin_ff.root <= '0;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         pst_ff[k] <= pst_in[k];
         ost_ff[k] <= ost_in[k];
      end
      proot_ff <= pst_ff[SQRT_STEPS-1].root;
      oterm_ff <= COST_W'(oprod[WGT_W+DIR_W-1:6]);
   end

   assign cost = {1'b0, proot_ff} + {1'b0, oterm_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
      end else if (cmd.load_query) begin
         best_valid_ff <= 1'b0;
      end else if (vld_ff[PIPE_LEN-1]) begin
         best_valid_ff <= 1'b1;
      end
      if (vld_ff[PIPE_LEN-1] && (!best_valid_ff || cost < best_cost_ff)) begin
         best_cost_ff <= cost;
         best_idx_ff  <= idx_ff[PIPE_LEN-1];
      end
      if (cmd.finish) begin
         out_found_ff <= best_valid_ff;
         out_index_ff <= best_valid_ff ? best_idx_ff : '0;
         out_cost_ff  <= best_valid_ff ? best_cost_ff[COST_W-1:0] : '0;
      end
   end

   assign sts.count_zero = (count_ff == '0);
   assign sts.full       = (count_ff == CNT_W'(REF_DEPTH));
   assign sts.last_issue = cmd.issue && ({1'b0, scan_addr_ff} == last_addr);
   assign sts.pipe_busy  = pipe_busy;
   assign sts.out_busy   = out_valid_ff && !rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_index  = out_index_ff;
   assign rsp_cost   = out_cost_ff;
   assign rsp_found  = out_found_ff;

endmodule

/* src/pose_nearest_neighbour_search.sv */
// Top level of the weighted pose nearest-neighbor search.
// Depends on pnns_pkg, pnns_ctrl, pnns_dpath and pnns_ram.
//
//   channel  ports   payload
//   req      req_*   tuser: mode; tdata: pos_x,y,z, dir_x,y,z
//   rsp      rsp_*   tuser: match_found; tdata: match_index, match_cost
//   csr      csr_*   orientation_weight
//
// A query reads the reference memory one entry per cycle into a
// 30-stage cost pipeline with a one-step-per-stage square root.
// Reset clears the count and sets the weight to 100; no memory sweep.
// A finished result waits in an output register; a new request is held off
// while a query runs, and longer while the previous result is still unaccepted.
module pose_nearest_neighbour_search import pnns_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [119:0]   req_tdata,  // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z
   input  logic [1:0]     req_tuser,  // mode
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [39:0]    rsp_tdata,  // match_index, match_cost, zero fill
   output logic           rsp_tuser,  // match_found
   input  logic           csr_wen,
   input  logic [9:0]     csr_wdata   // orientation_weight
);

   cmd_type           cmd;
   sts_type           sts;
   logic [IDX_W-1:0]  rsp_index;
   logic [COST_W-1:0] rsp_cost;

   pnns_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   pnns_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_data   (req_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_index  (rsp_index),
      .rsp_cost   (rsp_cost),
      .rsp_found  (rsp_tuser)
   );

   assign rsp_tdata = {3'b000, rsp_cost, rsp_index};

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("empty-set result carries nonzero payload");

   a_issue_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !sts.count_zero && !req_tready)
      else $error("scan issued on empty set or while accepting");

   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !sts.pipe_busy && !cmd.issue)
      else $error("result loaded while cost pipeline busy");

endmodule
